// ----- rtl/btaa_pkg.sv -----
// shared types and codes of the binary tree address allocator
package btaa_pkg;

    localparam int ADDR_W = 8;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_DESCEND,
        ST_LEAF,
        ST_UP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } res_t;

endpackage

// ----- rtl/btaa_ram.sv -----
// generic single-write single-read ram with registered read data
module btaa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/btaa_walk.sv -----
// tree walker: descends for allocate, checks the leaf, refreshes full marks upward
module btaa_walk
    import btaa_pkg::*;
#(
    parameter int ADDRESS_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_op,
    input  logic [ADDR_W-1:0]     in_address,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res,
    output logic                  rd_en,
    output logic [ADDRESS_BITS:0] rd_addr,
    input  logic                  rd_data,
    output logic                  wr_en,
    output logic [ADDRESS_BITS:0] wr_addr,
    output logic                  wr_data
);

    localparam int AB    = ADDRESS_BITS;
    localparam int AW    = AB + 1;
    localparam int LVL_W = (AB > 1) ? $clog2(AB) : 1;
    localparam int POOL  = 1 << AB;
    localparam logic [AW-1:0]    ROOT_NODE = AW'(1);
    localparam logic [LVL_W-1:0] LAST_LVL  = LVL_W'(AB - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [1:0]        op_reg, op_next;
    logic [AW-1:0]     node_reg, node_next;
    logic              val_reg, val_next;
    logic              ok_reg, ok_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;

    logic [AW-1:0] leaf_in;
    logic          in_range;
    logic [AW-1:0] chosen;
    logic [AW-1:0] parent;
    logic          want;
    logic          pval;

    // heap order: node n has children 2n and 2n+1, leaves start at the pool size
    assign leaf_in  = {1'b1, AB'(in_address)};
    assign in_range = int'(in_address) < POOL;
    // node_reg holds a left child while descending, so a full flag picks the right one
    assign chosen   = {node_reg[AW-1:1], rd_data};
    assign parent   = {1'b0, node_reg[AW-1:1]};
    assign want     = (op_reg == OP_RELEASE);
    assign pval     = val_reg & rd_data;
    assign res      = '{ok: ok_reg, addr: raddr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        node_reg  <= node_next;
        val_reg   <= val_next;
        ok_reg    <= ok_next;
        raddr_reg <= raddr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        level_next = level_reg;
        op_next    = op_reg;
        node_next  = node_reg;
        val_next   = val_reg;
        ok_next    = ok_reg;
        raddr_next = raddr_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    raddr_next = in_address;
                    ok_next    = 1'b0;
                    if (in_op == OP_ALLOC)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ROOT_NODE;
                        state_next = ST_ROOT;
                    end
                    else if ((in_op == OP_RESERVE || in_op == OP_RELEASE) && in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = leaf_in;
                        node_next  = leaf_in;
                        state_next = ST_LEAF;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (rd_data)
                begin
                    // pool full
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(2);
                    node_next  = AW'(2);
                    level_next = '0;
                    state_next = ST_DESCEND;
                end
            end
            ST_DESCEND:
            begin
                if (level_reg == LAST_LVL)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = chosen;
                    wr_data    = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = {chosen[AW-1:1], ~chosen[0]};
                    node_next  = chosen;
                    val_next   = 1'b1;
                    ok_next    = 1'b1;
                    raddr_next = ADDR_W'(chosen[AB-1:0]);
                    state_next = ST_UP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {chosen[AW-2:0], 1'b0};
                    node_next  = {chosen[AW-2:0], 1'b0};
                    level_next = level_reg + LVL_W'(1);
                end
            end
            ST_LEAF:
            begin
                if (rd_data == want)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = node_reg;
                    wr_data    = ~want;
                    rd_en      = 1'b1;
                    rd_addr    = {node_reg[AW-1:1], ~node_reg[0]};
                    val_next   = ~want;
                    ok_next    = 1'b1;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_UP:
            begin
                // rd_data is the sibling of node_reg, written value is the parent mark
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = pval;
                if (parent == ROOT_NODE)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {parent[AW-1:1], ~parent[0]};
                    node_next  = parent;
                    val_next   = pval;
                end
            end
            ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // the refresh reads a sibling while writing on the path, never the same entry
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same tree entry");

    // the unused heap slot is written only by the clearing pass
    a_no_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != ST_CLEAR) |-> (wr_addr != '0))
        else $error("write to unused tree slot");

    a_up_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP) |-> (node_reg != ROOT_NODE && node_reg != '0))
        else $error("upward refresh started at the root");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

endmodule

// ----- rtl/binary_tree_address_allocator_unit.sv -----
// Address pool allocator over 2^ADDRESS_BITS addresses kept as a binary tree of
// full marks in one synchronous ram (heap order, leaves hold taken bits). An
// allocate reads the root, descends one level per cycle and then refreshes the
// full marks back up one level per cycle; reserve and release check the leaf and
// then refresh upward the same way. An unused op or an address outside the pool
// is refused without a tree access, an allocate on a full pool at the root and a
// reserve or release at the leaf. The rate is set by the ram's single read port,
// one tree level per cycle. One item is in the walker at a time; a finished
// result waits in the output register while the next item is taken. After reset a
// clearing pass writes all 2^(ADDRESS_BITS+1) tree entries to zero before the
// first item.
module binary_tree_address_allocator_unit
    import btaa_pkg::*;
#(
    parameter int ADDRESS_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] result_address
    output logic [0:0]  m_axis_tuser    // [0] success
);

    localparam int AW = ADDRESS_BITS + 1;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    logic              m_valid_reg;
    logic              m_ok_reg;
    logic [ADDR_W-1:0] m_addr_reg;

    btaa_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_tree (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    btaa_walk #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_address (s_axis_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // output register, refilled in the cycle it is taken
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_ok_reg   <= res.ok;
            m_addr_reg <= res.addr;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_addr_reg;
    assign m_axis_tuser  = m_ok_reg;

endmodule

// ----- dv/binary_tree_address_allocator_unit_tb.sv -----
// testbench of the binary tree address allocator: random and directed pool traffic
class pool_scoreboard;

    bit              leaf_taken [256];
    btaa_pkg::res_t  grants_due [$];
    int              errors;

    function new();
        foreach (leaf_taken[i])
            leaf_taken[i] = 1'b0;
        errors = 0;
    endfunction

    function automatic bit pool_full();
        foreach (leaf_taken[i])
            if (!leaf_taken[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pending();
        return grants_due.size();
    endfunction

    // works out the grant for one accepted request and updates the pool
    function automatic void note_request(logic [1:0] op, logic [7:0] addr);
        btaa_pkg::res_t grant;
        bit             found;
        grant.ok   = 1'b0;
        grant.addr = addr;
        found      = 1'b0;
        case (op)
            btaa_pkg::OP_ALLOC:
            begin
                for (int i = 0; i < 256 && !found; i++)
                begin
                    if (!leaf_taken[i])
                    begin
                        found         = 1'b1;
                        leaf_taken[i] = 1'b1;
                        grant.ok      = 1'b1;
                        grant.addr    = i[7:0];
                    end
                end
            end
            btaa_pkg::OP_RESERVE:
            begin
                if (!leaf_taken[addr])
                begin
                    leaf_taken[addr] = 1'b1;
                    grant.ok         = 1'b1;
                end
            end
            btaa_pkg::OP_RELEASE:
            begin
                if (leaf_taken[addr])
                begin
                    leaf_taken[addr] = 1'b0;
                    grant.ok         = 1'b1;
                end
            end
            default: ;
        endcase
        grants_due.push_back(grant);
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_grant(logic ok, logic [7:0] addr);
        btaa_pkg::res_t want;
        if (grants_due.size() == 0)
        begin
            report_mismatch($sformatf("item ok=%0b addr=%0d with nothing expected", ok, addr));
        end
        else
        begin
            want = grants_due.pop_front();
            if (ok !== want.ok)
                report_mismatch($sformatf("success %0b, expected %0b", ok, want.ok));
            if (addr !== want.addr)
                report_mismatch($sformatf("result_address %0d, expected %0d", addr, want.addr));
        end
    endtask

endclass

module binary_tree_address_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import btaa_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_WAIT = 60;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    pool_scoreboard sb;
    int             send_calm;
    int             recv_calm;
    int             idle_cycles;

    binary_tree_address_allocator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int idle_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(logic [1:0] op, logic [7:0] addr);
        int gap;
        gap = idle_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, addr);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [1:0] pick_op(int w_alloc, int w_reserve, int w_release);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_alloc)
            return OP_ALLOC;
        if (r < w_alloc + w_reserve)
            return OP_RESERVE;
        if (r < w_alloc + w_reserve + w_release)
            return OP_RELEASE;
        return OP_UNUSED;
    endfunction

    task automatic random_phase(int count, int w_alloc, int w_reserve, int w_release);
        for (int i = 0; i < count; i++)
            send(pick_op(w_alloc, w_reserve, w_release), 8'($urandom));
    endtask

    // receiving side with its own stalls
    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_grant(m_axis_tuser[0], m_axis_tdata);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = idle_gap(recv_calm);
            end
            @(posedge clk);
        end
    end

    // ends a hung run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("binary_tree_address_allocator_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int fill_items;
        sb          = new();
        send_calm   = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ALLOC;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first grants, double reserve and release, unused op, skip over taken
        send(OP_ALLOC,   8'h5A);
        send(OP_ALLOC,   8'hFF);
        send(OP_RESERVE, 8'hFF);
        send(OP_RESERVE, 8'hFF);
        send(OP_RESERVE, 8'h00);
        send(OP_RESERVE, 8'h80);
        send(OP_RESERVE, 8'h7F);
        send(OP_ALLOC,   8'h00);
        send(OP_RELEASE, 8'h01);
        send(OP_ALLOC,   8'hAA);
        send(OP_RELEASE, 8'hFF);
        send(OP_RELEASE, 8'hFF);
        send(OP_RELEASE, 8'h55);
        send(OP_UNUSED,  8'hFF);
        send(OP_UNUSED,  8'h00);
        send(OP_RESERVE, 8'h02);
        send(OP_RELEASE, 8'h00);
        send(OP_ALLOC,   8'h33);
        send(OP_RESERVE, 8'h03);
        send(OP_ALLOC,   8'hCC);

        // sender holds off until every grant has come back
        wait_drained();

        // fill the pool completely, then hammer it while full
        fill_items = 0;
        while (!sb.pool_full() && fill_items < 500)
        begin
            send(pick_op(78, 16, 3), 8'($urandom));
            fill_items++;
        end
        random_phase(10, 70, 15, 0);

        // drain a good part of the pool, then mixed traffic near both ends
        random_phase(150, 15, 20, 60);
        random_phase(120, 35, 25, 35);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("binary_tree_address_allocator_unit_tb: PASS");
        else
            $display("binary_tree_address_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule
